### rtl/ppr_pkg.sv
// Package for the Poisson potential relaxation block.
// Shared types and constants: register indexes, item kinds, controller command and status.
package ppr_pkg;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] CFG_NUM_LAYERS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LOWER_MODE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_UPPER_MODE = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_PRE_FACTOR = 2'd3;

  localparam logic [1:0] BND_SURFACE  = 2'd0;
  localparam logic [1:0] BND_PERIODIC = 2'd3;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // numerator magnitude width and divider step counter width
  localparam int NUM_W = 68;
  localparam int CNT_W = 7;

  localparam logic [1:0] SLOT0 = 2'd0;
  localparam logic [1:0] SLOT1 = 2'd1;
  localparam logic [1:0] SLOT2 = 2'd2;

  typedef enum logic [2:0] {
    K_COPY,
    K_LSURF,
    K_USURF,
    K_INT,
    K_RANGE
  } ppr_kind_t;

  typedef struct packed {
    logic [1:0] rd_sel;
    logic       cap0;
    logic       cap1;
    logic       cap2;
    logic       wt;
    logic       mul;
    logic       num;
    logic       div_step;
    logic       load;
  } ppr_cmd_t;

  typedef struct packed {
    logic do_div;
    logic div_last;
    logic out_busy;
  } ppr_sts_t;

endpackage

### rtl/ppr_if.sv
// Request and result channel interfaces for the Poisson relaxation block.
// Valid/ready handshake with the payload carried alongside; no dependencies.
interface ppr_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [8:0]         layer;
  logic signed [31:0] permittivity;
  logic signed [31:0] charge_density;
  logic signed [31:0] old_potential;

  modport source (output valid, func, layer, permittivity, charge_density, old_potential,
                  input ready);
  modport sink (input valid, func, layer, permittivity, charge_density, old_potential,
                output ready);
endinterface

interface ppr_out_if;
  logic               valid;
  logic               ready;
  logic [8:0]         result_layer;
  logic signed [31:0] new_potential;
  logic               zero_denominator;
  logic               range_error;

  modport source (output valid, result_layer, new_potential, zero_denominator, range_error,
                  input ready);
  modport sink (input valid, result_layer, new_potential, zero_denominator, range_error,
                output ready);
endinterface

### rtl/ppr_ctrl.sv
// Sequencer for the Poisson relaxation block.
// Uses ppr_pkg command/status types; drives the datapath step by step.
module ppr_ctrl import ppr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ppr_sts_t sts,
  output logic     in_ready,
  output ppr_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD0  = 10'b00_0000_0010,
    S_RD1  = 10'b00_0000_0100,
    S_RD2  = 10'b00_0000_1000,
    S_CAP  = 10'b00_0001_0000,
    S_WT   = 10'b00_0010_0000,
    S_MUL  = 10'b00_0100_0000,
    S_NUM  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_RD0;
      S_RD0:  state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_CAP;
      S_CAP:  state_next = S_WT;
      S_WT:   state_next = sts.do_div ? S_MUL : S_DONE;
      S_MUL:  state_next = S_NUM;
      S_NUM:  state_next = S_DIV;
      S_DIV:  if (sts.div_last) state_next = S_DONE;
      S_DONE: if (!sts.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = SLOT0;
    case (state)
      S_RD1: begin
        cmd.rd_sel = SLOT1;
        cmd.cap0 = 1'b1;
      end
      S_RD2: begin
        cmd.rd_sel = SLOT2;
        cmd.cap1 = 1'b1;
      end
      S_CAP:  cmd.cap2 = 1'b1;
      S_WT:   cmd.wt = 1'b1;
      S_MUL:  cmd.mul = 1'b1;
      S_NUM:  cmd.num = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_DONE: cmd.load = !sts.out_busy;
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

### rtl/ppr_datapath.sv
// Datapath for the Poisson relaxation block: layer stores, boundary decode,
// multipliers, bit-serial divider and result register. Uses ppr_pkg.
module ppr_datapath import ppr_pkg::*; #(
  parameter int MAX_LAYERS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_func,
  input  logic [8:0]         in_layer,
  input  logic signed [31:0] in_perm,
  input  logic signed [31:0] in_chg,
  input  logic signed [31:0] in_pot,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  ppr_cmd_t           cmd,
  output ppr_sts_t           sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         result_layer,
  output logic signed [31:0] new_potential,
  output logic               zero_denominator,
  output logic               range_error
);

  localparam int AW = $clog2(MAX_LAYERS);

  // configuration
  logic [7:0]         num_layers;
  logic [1:0]         lower_mode;
  logic [1:0]         upper_mode;
  logic signed [31:0] pre_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_layers <= 8'd1;
      lower_mode <= 2'd1;
      upper_mode <= 2'd1;
      pre_factor <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_LAYERS: num_layers <= cfg_data[7:0];
        CFG_LOWER_MODE: lower_mode <= cfg_data[1:0];
        CFG_UPPER_MODE: upper_mode <= cfg_data[1:0];
        CFG_PRE_FACTOR: pre_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // layer stores
  logic [31:0] eps_mem [MAX_LAYERS];
  logic [31:0] chg_mem [MAX_LAYERS];
  logic [31:0] pot_mem [MAX_LAYERS];

  logic          wr_ok;
  logic [AW-1:0] wr_idx;
  assign wr_ok  = (in_layer != 9'd0) && (32'(in_layer) <= MAX_LAYERS);
  assign wr_idx = AW'(in_layer - 9'd1);

  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_WRITE && wr_ok) begin
      eps_mem[wr_idx] <= in_perm;
      chg_mem[wr_idx] <= in_chg;
      pot_mem[wr_idx] <= in_pot;
    end
  end

  // boundary decode at accept
  logic [9:0] m_raw, m, z;
  logic       periodic;
  ppr_kind_t  kind_n, kind;
  logic [9:0] a0_n, a1_n, a2_n, a0, a1, a2;

  assign m_raw    = 10'(num_layers) + 10'd2;
  assign m        = (32'(m_raw) > MAX_LAYERS) ? 10'(MAX_LAYERS) : m_raw;
  assign z        = 10'(in_layer);
  assign periodic = (lower_mode == BND_PERIODIC) || (upper_mode == BND_PERIODIC);

  always_comb begin
    kind_n = K_RANGE;
    a0_n   = 10'd1;
    a1_n   = 10'd1;
    a2_n   = 10'd1;
    if (z == 10'd0 || z > m) begin
      kind_n = K_RANGE;
    end else if (z == 10'd1) begin
      if (periodic) begin
        kind_n = K_COPY;
        a0_n   = m - 10'd1;
      end else if (lower_mode == BND_SURFACE) begin
        kind_n = K_LSURF;
        a1_n   = 10'd2;
      end else begin
        kind_n = K_COPY;
        a0_n   = 10'(lower_mode) + 10'd1;
      end
    end else if (z == m) begin
      if (periodic) begin
        kind_n = K_COPY;
        a0_n   = 10'd2;
      end else if (upper_mode == BND_SURFACE) begin
        kind_n = K_USURF;
        a0_n   = m - 10'd1;
        a1_n   = m;
      end else begin
        kind_n = K_COPY;
        // tiny lattice: mirror2 would step below layer 1
        a0_n   = (m > 10'(upper_mode)) ? m - 10'(upper_mode) : 10'd1;
      end
    end else begin
      kind_n = K_INT;
      a0_n   = z - 10'd1;
      a1_n   = z;
      a2_n   = z + 10'd1;
    end
  end

  logic [8:0] layer_q;

  always_ff @(posedge clk) begin
    if (in_fire && in_func == FUNC_COMPUTE) begin
      kind    <= kind_n;
      a0      <= a0_n;
      a1      <= a1_n;
      a2      <= a2_n;
      layer_q <= in_layer;
    end
  end

  // store reads, one address per cycle
  logic [9:0]         rd_a;
  logic [AW-1:0]      rd_idx;
  logic signed [31:0] eps_rd, chg_rd, pot_rd;

  always_comb begin
    case (cmd.rd_sel)
      SLOT1:   rd_a = a1;
      SLOT2:   rd_a = a2;
      default: rd_a = a0;
    endcase
  end
  assign rd_idx = AW'(rd_a - 10'd1);

  always_ff @(posedge clk) begin
    eps_rd <= eps_mem[rd_idx];
    chg_rd <= chg_mem[rd_idx];
    pot_rd <= pot_mem[rd_idx];
  end

  logic signed [31:0] e0, e1, e2, c0, c1, p0, p1, p2;

  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      e0 <= eps_rd;
      c0 <= chg_rd;
      p0 <= pot_rd;
    end
    if (cmd.cap1) begin
      e1 <= eps_rd;
      c1 <= chg_rd;
      p1 <= pot_rd;
    end
    if (cmd.cap2) begin
      e2 <= eps_rd;
      p2 <= pot_rd;
    end
  end

  // weights and denominator
  logic signed [33:0] wa_c, wb_c, den_c, wa, wb, den;
  logic signed [31:0] va_c, vb_c, q_c, va, vb, q;
  logic               relax, den_zero;

  assign relax = (kind == K_LSURF) || (kind == K_USURF) || (kind == K_INT);
  assign wa_c  = 34'(e0) + 34'(e1);
  assign wb_c  = (kind == K_INT) ? 34'(e1) + 34'(e2) : 34'sd0;
  assign den_c = wa_c + wb_c;
  assign va_c  = (kind == K_LSURF) ? p1 : p0;
  assign vb_c  = (kind == K_INT) ? p2 : 32'sd0;
  assign q_c   = (kind == K_LSURF) ? c0 : c1;

  always_ff @(posedge clk) begin
    if (cmd.wt) begin
      wa       <= wa_c;
      wb       <= wb_c;
      den      <= den_c;
      va       <= va_c;
      vb       <= vb_c;
      q        <= q_c;
      den_zero <= relax && (den_c == 34'sd0);
    end
  end

  // products
  logic signed [65:0] pa, pb;
  logic signed [64:0] pq;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pa <= 66'(wa) * 66'(va);
      pb <= 66'(wb) * 66'(vb);
      pq <= {64'(pre_factor) * 64'(q), 1'b0};
    end
  end

  // numerator, signs, then bit-serial restoring divide
  logic signed [NUM_W-1:0] num_c;
  logic [NUM_W-1:0]        nq;
  logic                    qneg;
  logic [33:0]             dmag;
  logic [34:0]             rem, rem_sh;
  logic                    ge;
  logic [CNT_W-1:0]        cnt;

  assign num_c  = NUM_W'(pa) + NUM_W'(pb) + NUM_W'(pq);
  assign rem_sh = {rem[33:0], nq[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (cmd.num) begin
      nq   <= num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
      qneg <= num_c[NUM_W-1] ^ den[33];
      dmag <= den[33] ? 34'(-den) : 34'(den);
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sh - {1'b0, dmag} : rem_sh;
      nq  <= {nq[NUM_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // saturate quotient to Q16.16
  logic [31:0] sat;
  always_comb begin
    if (!qneg) begin
      sat = (|nq[NUM_W-1:31]) ? 32'h7FFF_FFFF : nq[31:0];
    end else if ((|nq[NUM_W-1:32]) || (nq[31] && (|nq[30:0]))) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'(-nq[31:0]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_layer     <= layer_q;
      range_error      <= (kind == K_RANGE);
      zero_denominator <= den_zero;
      case (kind)
        K_RANGE: new_potential <= 32'sd0;
        K_COPY:  new_potential <= p0;
        default: new_potential <= den_zero ? 32'sd0 : sat;
      endcase
    end
  end

  assign sts.do_div   = relax && (den_c != 34'sd0);
  assign sts.div_last = (cnt == CNT_W'(NUM_W - 1));
  assign sts.out_busy = out_valid && !out_ready;

endmodule

### rtl/poisson_potential_relaxation_top.sv
// Top level of the 1D Poisson potential relaxation block (one Jacobi step per request).
// Depends on ppr_pkg, ppr_if, ppr_ctrl and ppr_datapath.

// A write request stores one layer's permittivity, charge and old potential and is
// taken whenever the block is idle. A compute request returns the relaxed potential
// of one layer. Boundary copies, out-of-range layers and zero denominators pass
// through three store reads (one address per cycle through the single read port),
// a capture step, a weight step and the load. Surface and interior layers take the
// same steps plus a multiply step, a numerator step and the bit-serial divider,
// which works through the 68-bit numerator bit by bit. One request is in work at a
// time; the load waits while the output is stalled, and a finished result waits in
// the output register while the next request is taken.
module poisson_potential_relaxation_top import ppr_pkg::*; #(
  parameter int MAX_LAYERS = 256
) (
  input  logic              clk,
  input  logic              rst,
  ppr_in_if.sink            in_ch,
  ppr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  ppr_cmd_t cmd;
  ppr_sts_t sts;
  logic     in_ready;
  logic     in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  ppr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire && in_ch.func == FUNC_COMPUTE),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ppr_datapath #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_fire),
    .in_func          (in_ch.func),
    .in_layer         (in_ch.layer),
    .in_perm          (in_ch.permittivity),
    .in_chg           (in_ch.charge_density),
    .in_pot           (in_ch.old_potential),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .result_layer     (out_ch.result_layer),
    .new_potential    (out_ch.new_potential),
    .zero_denominator (out_ch.zero_denominator),
    .range_error      (out_ch.range_error)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.range_error && out_ch.zero_denominator))
    else $error("range and zero-denominator flags both set");

  a_zero_den_value: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.zero_denominator) |-> (out_ch.new_potential == 32'sd0))
    else $error("zero denominator with nonzero potential");

  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.func == FUNC_COMPUTE) |=> !in_ch.ready)
    else $error("request taken while a compute is in work");

endmodule

### test/ppr_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side notes: the channel interfaces come from rtl/ppr_if.sv.
// This file holds the scoreboard class shared by the testbench top; depends on ppr_pkg.
package ppr_tb_pkg;
  import ppr_pkg::*;

  typedef struct {
    logic [8:0]  layer;
    logic [31:0] potential;
    logic        zden;
    logic        rerr;
  } relax_result_t;

  class relax_scoreboard;
    logic [31:0] eps_mem [256];
    logic [31:0] chg_mem [256];
    logic [31:0] pot_mem [256];
    logic [7:0]  num_layers;
    logic [1:0]  lower_mode, upper_mode;
    logic [31:0] pre_factor;
    relax_result_t pending[$];
    int errors;

    function new();
      num_layers = 1; lower_mode = 1; upper_mode = 1; pre_factor = 32'h10000;
      errors = 0;
      foreach (eps_mem[i]) begin
        eps_mem[i] = 0; chg_mem[i] = 0; pot_mem[i] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_NUM_LAYERS: num_layers = val[7:0];
        CFG_LOWER_MODE: lower_mode = val[1:0];
        CFG_UPPER_MODE: upper_mode = val[1:0];
        default:        pre_factor = val;
      endcase
    endfunction

    function int clampi(int l);
      if (l < 1) l = 1;
      if (l > 256) l = 256;
      return l - 1;
    endfunction

    function logic signed [63:0] eps_at(int l);
      return 64'(signed'(eps_mem[clampi(l)]));
    endfunction
    function logic signed [63:0] pot_at(int l);
      return 64'(signed'(pot_mem[clampi(l)]));
    endfunction
    function logic signed [63:0] chg_at(int l);
      return 64'(signed'(chg_mem[clampi(l)]));
    endfunction

    // exact weighted sum, truncating divide, then saturate to 32 bits
    function logic [31:0] relax(logic signed [63:0] wa, logic signed [63:0] va,
                                logic signed [63:0] wb, logic signed [63:0] vb,
                                logic signed [63:0] q, logic signed [63:0] den,
                                output logic zf);
      logic signed [127:0] num, quo, pf;
      zf = 0;
      if (den == 0) begin
        zf = 1;
        return 0;
      end
      pf = 128'(signed'(pre_factor));
      num = 128'(wa) * 128'(va) + 128'(wb) * 128'(vb) + 2 * pf * 128'(q);
      quo = num / 128'(den);
      if (quo > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
      if (quo < -128'sh80000000) return 32'h80000000;
      return quo[31:0];
    endfunction

    function void note_request(logic func, logic [8:0] layer, logic [31:0] eps,
                               logic [31:0] chg, logic [31:0] pot);
      relax_result_t r;
      int m, z;
      logic zf;
      logic signed [63:0] den, em, ep;
      if (func == FUNC_WRITE) begin
        if (layer >= 1 && layer <= 256) begin
          eps_mem[layer-1] = eps; chg_mem[layer-1] = chg; pot_mem[layer-1] = pot;
        end
        return;
      end
      m = int'(num_layers) + 2;
      if (m > 256) m = 256;
      r.layer = layer; r.potential = 0; r.zden = 0; r.rerr = 0;
      z = int'(layer);
      zf = 0;
      if (z == 0 || z > m) r.rerr = 1;
      else if (z == 1) begin
        if (lower_mode == BND_PERIODIC || upper_mode == BND_PERIODIC)
          r.potential = 32'(pot_at(m - 1));
        else if (lower_mode == BND_SURFACE) begin
          den = eps_at(1) + eps_at(2);
          r.potential = relax(den, pot_at(2), 64'sd0, 64'sd0, chg_at(1), den, zf);
        end else r.potential = 32'(pot_at(int'(lower_mode) + 1));
      end else if (z == m) begin
        if (lower_mode == BND_PERIODIC || upper_mode == BND_PERIODIC)
          r.potential = 32'(pot_at(2));
        else if (upper_mode == BND_SURFACE) begin
          den = eps_at(m - 1) + eps_at(m);
          r.potential = relax(den, pot_at(m - 1), 64'sd0, 64'sd0, chg_at(m), den, zf);
        end else r.potential = 32'(pot_at(m - int'(upper_mode)));
      end else begin
        em = eps_at(z - 1) + eps_at(z);
        ep = eps_at(z) + eps_at(z + 1);
        r.potential = relax(em, pot_at(z - 1), ep, pot_at(z + 1), chg_at(z), em + ep, zf);
      end
      r.zden = zf;
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [8:0] layer, logic [31:0] pot, logic zf, logic rf);
      relax_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result layer %0d", layer));
        return;
      end
      e = pending.pop_front();
      if (layer !== e.layer)
        report($sformatf("result_layer %0d, want %0d", layer, e.layer));
      if (pot !== e.potential)
        report($sformatf("layer %0d new_potential %h, want %h", e.layer, pot, e.potential));
      if (zf !== e.zden)
        report($sformatf("layer %0d zero_denominator %b, want %b", e.layer, zf, e.zden));
      if (rf !== e.rerr)
        report($sformatf("layer %0d range_error %b, want %b", e.layer, rf, e.rerr));
    endtask
  endclass
endpackage

### test/poisson_potential_relaxation_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for poisson_potential_relaxation_top: random and directed layer
// writes and computes checked against the scoreboard in ppr_tb_pkg; needs ppr_pkg, ppr_if.
module poisson_potential_relaxation_top_tb;
  import ppr_pkg::*;
  import ppr_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  ppr_in_if  in_ch();
  ppr_out_if out_ch();

  poisson_potential_relaxation_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  relax_scoreboard board;
  bit idle_on = 1;
  int hold_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 0;
      hold_cycles = $urandom_range(0, 14);
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result(out_ch.result_layer, out_ch.new_potential,
                         out_ch.zero_denominator, out_ch.range_error);
  end

  // valid stays up between back-to-back requests; it drops only for a gap, a register write or a drain
  task automatic send(logic func, logic [8:0] layer, logic [31:0] eps = 0,
                      logic [31:0] chg = 0, logic [31:0] pot = 0);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.func <= func; in_ch.layer <= layer;
    in_ch.permittivity <= eps; in_ch.charge_density <= chg; in_ch.old_potential <= pot;
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(func, layer, eps, chg, pot);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_ch.valid <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65536 * 4);
      3: return -$urandom_range(0, 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  // fill the whole lattice so every compute reads written entries
  task automatic fill_lattice(int m);
    for (int l = 1; l <= m; l++)
      send(FUNC_WRITE, 9'(l), rand_val(), rand_val(), rand_val());
  endtask

  task automatic random_phase(int n, int m);
    int l;
    for (int i = 0; i < n; i++) begin
      l = $urandom_range(1, m);
      if ($urandom_range(0, 2) == 0)
        send(FUNC_WRITE, 9'(l), rand_val(), rand_val(), rand_val());
      else if ($urandom_range(0, 15) == 0)
        send(FUNC_COMPUTE, 9'($urandom_range(m + 1, 511)));
      else
        send(FUNC_COMPUTE, 9'(l));
    end
  endtask

  initial begin
    int m;
    int nl_set[6];
    nl_set = '{1, 2, 5, 20, 254, 3};
    in_ch.valid <= 0; in_ch.func <= 0; in_ch.layer <= 0;
    in_ch.permittivity <= 0; in_ch.charge_density <= 0; in_ch.old_potential <= 0;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, 3-layer lattice, extremes and zero denominator
    send(FUNC_WRITE, 1, 32'h10000, 32'h7FFFFFFF, 32'h80000000);
    send(FUNC_WRITE, 2, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send(FUNC_WRITE, 3, 32'h80000000, 32'h10000, 32'h00020000);
    send(FUNC_WRITE, 0, 1, 1, 1);
    send(FUNC_WRITE, 9'd511, 1, 1, 1);
    for (int l = 0; l <= 4; l++) send(FUNC_COMPUTE, 9'(l));
    send(FUNC_COMPUTE, 9'd511);
    drain();
    write_reg(CFG_LOWER_MODE, BND_SURFACE);
    write_reg(CFG_UPPER_MODE, BND_SURFACE);
    write_reg(CFG_PRE_FACTOR, 32'h80000000);
    send(FUNC_WRITE, 1, 32'h10000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(FUNC_WRITE, 2, 32'hFFFF0000, 32'h10000, 32'h10000);
    send(FUNC_WRITE, 3, 0, 32'h80000000, 32'h80000000);
    for (int l = 1; l <= 3; l++) send(FUNC_COMPUTE, 9'(l));
    drain();

    // random phases across lattice sizes and boundary modes
    for (int p = 0; p < 6; p++) begin
      m = nl_set[p] + 2;
      if (m > 256) m = 256;
      write_reg(CFG_NUM_LAYERS, nl_set[p]);
      write_reg(CFG_LOWER_MODE, $urandom_range(0, 3));
      write_reg(CFG_UPPER_MODE, (p == 1) ? BND_PERIODIC : 2'($urandom_range(0, 2)));
      write_reg(CFG_PRE_FACTOR, (p == 2) ? 32'h7FFFFFFF : rand_val());
      if (p == 5) idle_on = 0;
      fill_lattice(m);
      if (p == 3) hold_cycles = 2000;
      random_phase((m > 100) ? 50 : 40, m);
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** poisson_potential_relaxation_top: PASSED **");
    else
      $display("** poisson_potential_relaxation_top: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** poisson_potential_relaxation_top: FAILED **");
    $finish;
  end
endmodule

### poisson_potential_relaxation_top.f
rtl/ppr_pkg.sv
rtl/ppr_if.sv
rtl/ppr_ctrl.sv
rtl/ppr_datapath.sv
rtl/poisson_potential_relaxation_top.sv
test/ppr_tb_if.sv
test/poisson_potential_relaxation_top_tb.sv
